// File: hdl/nqfq_pkg.sv
// ----------------------------------------------------------------------------
// nqfq_pkg
// Shared constants and types for the fixed-queen N-queens solution counter.
// ----------------------------------------------------------------------------
package nqfq_pkg;

  localparam int MAX_SIZE_DEF = 12;   // default largest board side
  localparam int BOARD_W      = 4;    // width of the board side register
  localparam int POS_W        = 4;    // width of a queen row or column
  localparam int POS_CMP_W    = 5;    // compare width for position checks
  localparam int COUNT_W      = 14;   // width of the solution count

  localparam logic [BOARD_W-1:0] BOARD_RESET = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRY,
    ST_POP
  } state_t;

endpackage

// File: hdl/nqfq_probe.sv
// ----------------------------------------------------------------------------
// nqfq_probe
// Shared square probe: decodes a (row, column) square into its column and
// diagonal mask bits and flags a clash with the current masks.
// ----------------------------------------------------------------------------
module nqfq_probe #(
  parameter int  MAX_SIZE = 12,
  localparam int RC_W     = $clog2(MAX_SIZE + 1),
  localparam int DIAG_N   = 2 * MAX_SIZE - 1,
  localparam int DIAG_W   = (DIAG_N > 1) ? $clog2(DIAG_N) : 1
) (
  input  logic [RC_W-1:0]     row,
  input  logic [RC_W-1:0]     col,
  input  logic [MAX_SIZE-1:0] col_used,
  input  logic [DIAG_N-1:0]   down_used,
  input  logic [DIAG_N-1:0]   up_used,
  output logic [MAX_SIZE-1:0] col_bit,
  output logic [DIAG_N-1:0]   down_bit,
  output logic [DIAG_N-1:0]   up_bit,
  output logic                conflict
);

  logic [DIAG_W-1:0] down_idx;
  logic [DIAG_W-1:0] up_idx;

  // down diagonal is row - col, offset so it never goes negative
  assign down_idx = DIAG_W'(row) + DIAG_W'(MAX_SIZE - 1) - DIAG_W'(col);
  assign up_idx   = DIAG_W'(row) + DIAG_W'(col);

  assign col_bit  = MAX_SIZE'(1) << col;
  assign down_bit = DIAG_N'(1) << down_idx;
  assign up_bit   = DIAG_N'(1) << up_idx;

  assign conflict = (|(col_bit & col_used)) | (|(down_bit & down_used)) |
                    (|(up_bit & up_used));

endmodule

// File: hdl/n_queens_fixed_queen_counter.sv
// ----------------------------------------------------------------------------
// n_queens_fixed_queen_counter
// Counts every N-queens placement that includes one given queen, by an
// iterative backtracking search over a column stack.
// ----------------------------------------------------------------------------
//  channel   signals                                   transaction when
//  request   start, busy, queen_row, queen_col         start && !busy
//  result    done, solution_count, solution_exists,    done (one cycle)
//            bad_position
//  config    cfg_valid, cfg_ready, board_size          cfg_valid && cfg_ready
//
//  Busy stays high while the search tests columns, runs rows out of columns,
//  passes the given queen's row, counts full boards and steps back rows, and
//  through the final step to finish; done then follows. The search makes one
//  square probe per cycle. An off-board position gives done the next cycle
//  with busy kept low. Reset is synchronous, active high, and restores a board
//  side of 8. The receiver cannot stall: done is one cycle.
// ----------------------------------------------------------------------------
module n_queens_fixed_queen_counter
  import nqfq_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [POS_W-1:0]   queen_row,
  input  logic [POS_W-1:0]   queen_col,
  output logic               done,
  output logic [COUNT_W-1:0] solution_count,
  output logic               solution_exists,
  output logic               bad_position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BOARD_W-1:0] board_size
);

  localparam int RC_W   = $clog2(MAX_SIZE + 1);
  localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DIAG_N = 2 * MAX_SIZE - 1;

  state_t state, state_next;

  logic [BOARD_W-1:0]  board_reg;
  logic [RC_W-1:0]     side, side_next;
  logic [RC_W-1:0]     fixed_row, fixed_row_next;
  logic [RC_W-1:0]     row, row_next;
  logic [RC_W-1:0]     col, col_next;
  logic [MAX_SIZE-1:0] col_used, col_used_next;
  logic [DIAG_N-1:0]   down_used, down_used_next;
  logic [DIAG_N-1:0]   up_used, up_used_next;
  logic [COUNT_W-1:0]  count, count_next;
  logic                exists_next, bad_next, done_next;
  logic [IDX_W-1:0]    stack [MAX_SIZE];
  logic                stack_we;

  logic [RC_W-1:0]     op_row, op_col;
  logic [RC_W-1:0]     prev_row;
  logic [IDX_W-1:0]    prev_col;
  logic [MAX_SIZE-1:0] col_bit;
  logic [DIAG_N-1:0]   down_bit, up_bit;
  logic                conflict;
  logic [RC_W-1:0]     side_in;
  logic                pos_bad;
  logic                accept;

  assign accept   = start && !busy;
  assign prev_row = row - RC_W'(1);
  assign prev_col = stack[prev_row[IDX_W-1:0]];

  // clamp the configured side to the largest board built
  assign side_in = (POS_CMP_W'(board_reg) > POS_CMP_W'(MAX_SIZE)) ?
                   RC_W'(MAX_SIZE) : RC_W'(board_reg);
  assign pos_bad = (POS_CMP_W'(queen_row) >= POS_CMP_W'(side_in)) ||
                   (POS_CMP_W'(queen_col) >= POS_CMP_W'(side_in));

  nqfq_probe #(
    .MAX_SIZE (MAX_SIZE)
  ) u_probe (
    .row       (op_row),
    .col       (op_col),
    .col_used  (col_used),
    .down_used (down_used),
    .up_used   (up_used),
    .col_bit   (col_bit),
    .down_bit  (down_bit),
    .up_bit    (up_bit),
    .conflict  (conflict)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !pos_bad) state_next = ST_TRY;
      end
      ST_TRY: begin
        if (row == side) begin
          state_next = ST_POP;
        end else if (row != fixed_row && col == side) begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (row == '0) begin
          state_next = ST_IDLE;
        end else if (prev_row != fixed_row) begin
          state_next = ST_TRY;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and probe operand selection
  always_comb begin
    busy      = 1'b1;
    cfg_ready = 1'b0;
    op_row    = row;
    op_col    = col;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
        op_row    = RC_W'(queen_row);
        op_col    = RC_W'(queen_col);
      end
      ST_TRY: begin
        op_row = row;
        op_col = col;
      end
      ST_POP: begin
        op_row = prev_row;
        op_col = RC_W'(prev_col);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // datapath
  always_comb begin
    side_next      = side;
    fixed_row_next = fixed_row;
    row_next       = row;
    col_next       = col;
    col_used_next  = col_used;
    down_used_next = down_used;
    up_used_next   = up_used;
    count_next     = count;
    exists_next    = solution_exists;
    bad_next       = bad_position;
    done_next      = 1'b0;
    stack_we       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          side_next      = side_in;
          fixed_row_next = RC_W'(queen_row);
          row_next       = '0;
          col_next       = '0;
          count_next     = '0;
          col_used_next  = col_bit;
          down_used_next = down_bit;
          up_used_next   = up_bit;
          if (pos_bad) begin
            done_next   = 1'b1;
            exists_next = 1'b0;
            bad_next    = 1'b1;
          end
        end
      end
      ST_TRY: begin
        if (row == side) begin
          // full board: count it and back off
          if (count != COUNT_MAX) count_next = count + COUNT_W'(1);
        end else if (row == fixed_row) begin
          row_next = row + RC_W'(1);
          col_next = '0;
        end else if (col != side) begin
          if (!conflict) begin
            col_used_next  = col_used | col_bit;
            down_used_next = down_used | down_bit;
            up_used_next   = up_used | up_bit;
            stack_we       = 1'b1;
            row_next       = row + RC_W'(1);
            col_next       = '0;
          end else begin
            col_next = col + RC_W'(1);
          end
        end
      end
      ST_POP: begin
        if (row == '0) begin
          done_next   = 1'b1;
          exists_next = (count != '0);
          bad_next    = 1'b0;
        end else if (prev_row == fixed_row) begin
          row_next = prev_row;
        end else begin
          // lift the queen of the row above and try its next column
          col_used_next  = col_used & ~col_bit;
          down_used_next = down_used & ~down_bit;
          up_used_next   = up_used & ~up_bit;
          row_next       = prev_row;
          col_next       = RC_W'(prev_col) + RC_W'(1);
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      board_reg <= BOARD_RESET;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) board_reg <= board_size;
    end
  end

  always_ff @(posedge clk) begin
    side            <= side_next;
    fixed_row       <= fixed_row_next;
    row             <= row_next;
    col             <= col_next;
    col_used        <= col_used_next;
    down_used       <= down_used_next;
    up_used         <= up_used_next;
    count           <= count_next;
    solution_exists <= exists_next;
    bad_position    <= bad_next;
    if (stack_we) stack[row[IDX_W-1:0]] <= IDX_W'(col);
  end

  assign solution_count = count;

endmodule

// File: hdl/nqfq_checker.sv
// ----------------------------------------------------------------------------
// nqfq_checker
// Port-level checks for the fixed-queen N-queens counter, bound to the top.
// ----------------------------------------------------------------------------
module nqfq_checker
  import nqfq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [COUNT_W-1:0] solution_count,
  input logic               solution_exists,
  input logic               bad_position
);

  // a result comes only from a request taken last cycle or a search ending
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still searching");

  a_exists_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (solution_exists == (solution_count != '0)))
    else $error("solution flag disagrees with count");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_position) |-> (solution_count == '0 && !solution_exists))
    else $error("off-board request returned a count");

  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("search began without a request");

endmodule

bind n_queens_fixed_queen_counter nqfq_checker u_nqfq_checker (.*);
